>>> sv/aabb_pkg.sv
// Package for the box table mover: table size, transaction structs and
// the command and status groups between controller and datapath.
// Depends on nothing; every other file uses it by scoped names.
`default_nettype none

package aabb_pkg;

  // Table depth and the widths derived from it.
  localparam int MAX_BOXES = 16;
  localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MOVE  = 1'b1;

  // Input transaction.
  typedef struct packed {
    logic               op;
    logic [3:0]         box_index;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic [15:0]        box_width;
    logic [15:0]        box_height;
    logic               present;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic [15:0]        step_time;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic signed [15:0] pos_x_out;
    logic signed [15:0] pos_y_out;
    logic               moved_x;
    logic               moved_y;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic read_self;
    logic write_entry;
    logic calc_x;
    logic calc_y;
    logic scan_start;
    logic scan_run;
    logic commit_x;
    logic commit_y;
    logic finish;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_write;
    logic can_move;
    logic scan_done;
  } stat_t;

endpackage

`default_nettype wire

>>> sv/aabb_ctrl.sv
// Controller state machine for the box table mover.
// Depends on aabb_pkg for the command and status structs.
`default_nettype none

module aabb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire aabb_pkg::stat_t stat,
  output aabb_pkg::ctrl_t     ctrl,
  output logic                busy
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CALCX = 3'd2;
  localparam logic [2:0] S_SCANX = 3'd3;
  localparam logic [2:0] S_CALCY = 3'd4;
  localparam logic [2:0] S_SCANY = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    ctrl = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          ctrl.load_item = 1'b1;
          state_next = S_RD;
        end
      end
      S_RD: begin
        ctrl.read_self = 1'b1;
        if (stat.is_write) begin
          ctrl.write_entry = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_CALCX;
        end
      end
      S_CALCX: begin
        ctrl.calc_x = 1'b1;
        if (stat.can_move) begin
          ctrl.scan_start = 1'b1;
          state_next = S_SCANX;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCANX: begin
        ctrl.scan_run = 1'b1;
        if (stat.scan_done) begin
          ctrl.commit_x = 1'b1;
          state_next = S_CALCY;
        end
      end
      S_CALCY: begin
        ctrl.calc_y = 1'b1;
        ctrl.scan_start = 1'b1;
        state_next = S_SCANY;
      end
      S_SCANY: begin
        ctrl.scan_run = 1'b1;
        if (stat.scan_done) begin
          ctrl.commit_y = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        ctrl.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/aabb_datapath.sv
// Datapath for the box table mover: box table memories, displacement
// multipliers, the candidate box and the serial overlap scan.
// Depends on aabb_pkg for the structs and table size.
`default_nettype none

module aabb_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire aabb_pkg::in_t   item,
  input  wire aabb_pkg::ctrl_t ctrl,
  output aabb_pkg::stat_t      stat,
  output aabb_pkg::out_t       result,
  output logic                 done
);

  localparam int AW = aabb_pkg::AW;
  localparam int CW = aabb_pkg::CW;

  // Rounds a Q13.20 displacement to Q12.4, adds it and saturates.
  function automatic logic signed [15:0] advance(input logic signed [15:0] pos,
                                                 input logic signed [32:0] prod);
    logic signed [33:0] biased;
    logic signed [17:0] disp;
    logic signed [18:0] sum;
    biased = {prod[32], prod} + 34'sd32768;
    disp = biased[33:16];
    sum = {{3{pos[15]}}, pos} + {disp[17], disp};
    if (sum > 19'sd32767) begin
      advance = 16'sh7FFF;
    end else if (sum < -19'sd32768) begin
      advance = 16'sh8000;
    end else begin
      advance = sum[15:0];
    end
  endfunction

  aabb_pkg::in_t item_q;

  logic [AW-1:0] self_addr;
  logic          in_range;

  // Box table: one write address, one read port for the mover and one for the scan.
  logic [15:0] mem_x [aabb_pkg::MAX_BOXES];
  logic [15:0] mem_y [aabb_pkg::MAX_BOXES];
  logic [15:0] mem_w [aabb_pkg::MAX_BOXES];
  logic [15:0] mem_h [aabb_pkg::MAX_BOXES];
  logic [aabb_pkg::MAX_BOXES-1:0] written;
  logic [aabb_pkg::MAX_BOXES-1:0] present;

  logic signed [15:0] sx;
  logic signed [15:0] sy;
  logic [15:0]        sw;
  logic [15:0]        sh;
  logic               self_wr;
  logic signed [15:0] sx_m;
  logic signed [15:0] sy_m;

  logic signed [32:0] prod_x;
  logic signed [32:0] prod_y;

  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic signed [15:0] tx;
  logic signed [15:0] ty;
  logic [15:0]        tw;
  logic [15:0]        th;
  logic               moved_x;
  logic               moved_y;

  logic [CW-1:0]      k;
  logic [AW-1:0]      k_addr;
  logic [AW-1:0]      kd;
  logic               pend;
  logic               issue;
  logic               hit;
  logic signed [15:0] bx;
  logic signed [15:0] by;
  logic [15:0]        bw;
  logic [15:0]        bh;
  logic               overlap;

  aabb_pkg::out_t result_q;

  // Latch the accepted transaction.
  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      item_q <= item;
    end
  end

  assign self_addr = AW'(item_q.box_index);
  assign in_range  = (32'(item_q.box_index) < 32'(aabb_pkg::MAX_BOXES));

  // Table writes: a full entry for a write, one edge for a committed move.
  always_ff @(posedge clk) begin
    if (ctrl.write_entry && in_range) begin
      mem_x[self_addr] <= item_q.new_x;
      mem_y[self_addr] <= item_q.new_y;
      mem_w[self_addr] <= item_q.box_width;
      mem_h[self_addr] <= item_q.box_height;
    end else if (ctrl.commit_x && !hit) begin
      mem_x[self_addr] <= tx;
    end else if (ctrl.commit_y && !hit) begin
      mem_y[self_addr] <= ty;
    end
  end

  // Written and present flags, cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      present <= '0;
    end else if (ctrl.write_entry && in_range) begin
      written[self_addr] <= 1'b1;
      present[self_addr] <= item_q.present;
    end
  end

  // Mover read port and the two displacement products.
  always_ff @(posedge clk) begin
    if (ctrl.read_self) begin
      sx      <= mem_x[self_addr];
      sy      <= mem_y[self_addr];
      sw      <= mem_w[self_addr];
      sh      <= mem_h[self_addr];
      self_wr <= written[self_addr];
      prod_x  <= $signed(item_q.vel_x) * $signed({1'b0, item_q.step_time});
      prod_y  <= $signed(item_q.vel_y) * $signed({1'b0, item_q.step_time});
    end
  end

  // An entry never written reads its position as zero.
  assign sx_m = self_wr ? sx : 16'sd0;
  assign sy_m = self_wr ? sy : 16'sd0;

  // Candidate box, current position and commits.
  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      moved_x <= 1'b0;
      moved_y <= 1'b0;
    end
    if (ctrl.calc_x) begin
      cur_x <= sx_m;
      cur_y <= sy_m;
      tx    <= advance(sx_m, prod_x);
      ty    <= sy_m;
      tw    <= sw;
      th    <= sh;
    end
    if (ctrl.calc_y) begin
      tx <= cur_x;
      ty <= advance(cur_y, prod_y);
    end
    if (ctrl.commit_x && !hit) begin
      cur_x   <= tx;
      moved_x <= 1'b1;
    end
    if (ctrl.commit_y && !hit) begin
      cur_y   <= ty;
      moved_y <= 1'b1;
    end
  end

  // Scan read port: one entry is fetched per cycle.
  assign k_addr = k[AW-1:0];
  assign issue  = ctrl.scan_run && (k < CW'(aabb_pkg::MAX_BOXES));

  always_ff @(posedge clk) begin
    if (issue) begin
      bx <= mem_x[k_addr];
      by <= mem_y[k_addr];
      bw <= mem_w[k_addr];
      bh <= mem_h[k_addr];
    end
  end

  // Strict overlap of the candidate with the fetched entry, at full width.
  always_comb begin
    logic signed [17:0] ax18;
    logic signed [17:0] ay18;
    logic signed [17:0] bx18;
    logic signed [17:0] by18;
    ax18 = {{2{tx[15]}}, tx};
    ay18 = {{2{ty[15]}}, ty};
    bx18 = {{2{bx[15]}}, bx};
    by18 = {{2{by[15]}}, by};
    overlap = (ax18 < bx18 + $signed({2'b00, bw})) &&
              (ax18 + $signed({2'b00, tw}) > bx18) &&
              (ay18 < by18 + $signed({2'b00, bh})) &&
              (ay18 + $signed({2'b00, th}) > by18);
  end

  // Scan counter, fetch pipeline flag and hit accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= '0;
      pend <= 1'b0;
      hit  <= 1'b0;
      kd   <= '0;
    end else if (ctrl.scan_start) begin
      k    <= '0;
      pend <= 1'b0;
      hit  <= 1'b0;
    end else if (ctrl.scan_run) begin
      if (issue) begin
        k <= k + CW'(1);
      end
      pend <= issue;
      kd   <= k_addr;
      if (pend && present[kd] && (kd != self_addr) && overlap) begin
        hit <= 1'b1;
      end
    end
  end

  assign stat.is_write  = (item_q.op == aabb_pkg::OP_WRITE);
  assign stat.can_move  = in_range && present[self_addr] &&
                          ((item_q.vel_x != 16'sd0) || (item_q.vel_y != 16'sd0));
  assign stat.scan_done = (k == CW'(aabb_pkg::MAX_BOXES)) && !pend;

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      if (!in_range) begin
        result_q <= '0;
      end else if (item_q.op == aabb_pkg::OP_WRITE) begin
        result_q.pos_x_out <= item_q.new_x;
        result_q.pos_y_out <= item_q.new_y;
        result_q.moved_x   <= 1'b0;
        result_q.moved_y   <= 1'b0;
      end else begin
        result_q.pos_x_out <= cur_x;
        result_q.pos_y_out <= cur_y;
        result_q.moved_x   <= moved_x;
        result_q.moved_y   <= moved_y;
      end
    end
  end

  assign result = result_q;

endmodule

`default_nettype wire

>>> sv/aabb_move_and_collide.sv
// Top level of the box table mover: joins the controller and the datapath.
// Depends on aabb_pkg, aabb_ctrl and aabb_datapath.
//
// The block holds a table of aabb_pkg::MAX_BOXES boxes and takes one
// transaction at a time: start is accepted while busy is low, and the result
// appears on result for exactly one cycle with done high, which must be
// captured then since it cannot be held off. A write transaction passes
// through the read and done states only. A move of an absent entry or with
// zero velocity also passes the X calculation state. In a real move the
// table is scanned one entry per cycle through a single read port, once for
// the X try and once for the Y try, each scan ending with a fetch and
// compare drain. The next transaction may be started in the cycle in which
// done is high.
`default_nettype none

module aabb_move_and_collide (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire aabb_pkg::in_t item,
  output logic               busy,
  output aabb_pkg::out_t     result,
  output logic               done
);

  aabb_pkg::ctrl_t ctrl;
  aabb_pkg::stat_t stat;

  aabb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  aabb_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctrl   (ctrl),
    .stat   (stat),
    .result (result),
    .done   (done)
  );

`ifndef ASSERT_OFF
  // A result is only shown once the controller has gone back to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An accepted transaction always makes the block busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not start");

  // Each transaction gives one result strobe of a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // Commits happen only once the scan has drained.
  a_commit_done: assert property (@(posedge clk) disable iff (rst)
    (ctrl.commit_x || ctrl.commit_y) |-> stat.scan_done)
    else $error("commit before the scan finished");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for the box table mover: directed and random write and
// move transactions, with a scoreboard that predicts every result.
// Depends on aabb_pkg and aabb_move_and_collide.
`default_nettype none

module testbench;

  // Scoreboard: its own copy of the box table and the results still owed.
  class box_table_model;
    logic signed [15:0] left_q [aabb_pkg::MAX_BOXES];
    logic signed [15:0] top_q [aabb_pkg::MAX_BOXES];
    logic [15:0]        wide_q [aabb_pkg::MAX_BOXES];
    logic [15:0]        tall_q [aabb_pkg::MAX_BOXES];
    bit                 live_q [aabb_pkg::MAX_BOXES];
    aabb_pkg::out_t     positions_due [$];
    int                 errors;

    function new();
      for (int k = 0; k < aabb_pkg::MAX_BOXES; k++) begin
        left_q[k] = '0;
        top_q[k]  = '0;
        wide_q[k] = '0;
        tall_q[k] = '0;
        live_q[k] = 1'b0;
      end
      errors = 0;
    endfunction

    // Position plus velocity times step, rounded to nearest with ties up,
    // then clamped to the signed 16-bit range.
    function logic signed [15:0] advance_axis(logic signed [15:0] pos,
                                              logic signed [15:0] vel,
                                              logic [15:0] step);
      longint prod;
      longint sum;
      prod = longint'(vel) * longint'(step);
      sum = longint'(pos) + ((prod + 64'sd32768) >>> 16);
      if (sum > 32767) begin
        sum = 32767;
      end else if (sum < -32768) begin
        sum = -32768;
      end
      return sum[15:0];
    endfunction

    // Strict overlap against every present entry except the mover itself.
    function bit overlaps_other(int self, longint x, longint y, longint w, longint h);
      for (int k = 0; k < aabb_pkg::MAX_BOXES; k++) begin
        if (k != self && live_q[k] &&
            x < longint'(left_q[k]) + longint'(wide_q[k]) && x + w > longint'(left_q[k]) &&
            y < longint'(top_q[k]) + longint'(tall_q[k]) && y + h > longint'(top_q[k]))
          return 1'b1;
      end
      return 1'b0;
    endfunction

    // Apply one accepted transaction to the table and queue its result.
    function void note_item(aabb_pkg::in_t t);
      aabb_pkg::out_t     e;
      int                 i;
      logic signed [15:0] cand;
      e = '0;
      i = int'(t.box_index);
      if (t.op == aabb_pkg::OP_WRITE) begin
        left_q[i] = t.new_x;
        top_q[i]  = t.new_y;
        wide_q[i] = t.box_width;
        tall_q[i] = t.box_height;
        live_q[i] = t.present;
      end else if (live_q[i] && (t.vel_x != 0 || t.vel_y != 0)) begin
        cand = advance_axis(left_q[i], t.vel_x, t.step_time);
        if (!overlaps_other(i, longint'(cand), longint'(top_q[i]),
                            longint'(wide_q[i]), longint'(tall_q[i]))) begin
          left_q[i] = cand;
          e.moved_x = 1'b1;
        end
        cand = advance_axis(top_q[i], t.vel_y, t.step_time);
        if (!overlaps_other(i, longint'(left_q[i]), longint'(cand),
                            longint'(wide_q[i]), longint'(tall_q[i]))) begin
          top_q[i] = cand;
          e.moved_y = 1'b1;
        end
      end
      e.pos_x_out = left_q[i];
      e.pos_y_out = top_q[i];
      positions_due.push_back(e);
    endfunction

    // Compare one result with the oldest owed one.
    function void check_result(aabb_pkg::out_t r);
      aabb_pkg::out_t e;
      if (positions_due.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d mx=%0b my=%0b", $time,
                 r.pos_x_out, r.pos_y_out, r.moved_x, r.moved_y);
        errors++;
        return;
      end
      e = positions_due.pop_front();
      if (r.pos_x_out !== e.pos_x_out || r.pos_y_out !== e.pos_y_out ||
          r.moved_x !== e.moved_x || r.moved_y !== e.moved_y) begin
        $display("%0t: mismatch expected x=%0d y=%0d mx=%0b my=%0b actual x=%0d y=%0d mx=%0b my=%0b",
                 $time, e.pos_x_out, e.pos_y_out, e.moved_x, e.moved_y,
                 r.pos_x_out, r.pos_y_out, r.moved_x, r.moved_y);
        errors++;
      end
    endfunction
  endclass

  logic           clk;
  logic           rst;
  logic           start;
  aabb_pkg::in_t  item;
  logic           busy;
  aabb_pkg::out_t result;
  logic           done;
  box_table_model table_sb;
  int             burst_left;

  aabb_move_and_collide DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .result(result),
    .done(done)
  );

  // Clock with a period of 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Results cannot be held off, so every done cycle is checked.
  always @(posedge clk) begin
    if (!rst && done) begin
      table_sb.check_result(result);
    end
  end

  // Write transaction; the move fields carry junk the block must ignore.
  function automatic aabb_pkg::in_t write_cmd(int idx, int x, int y, int w, int h, bit p);
    aabb_pkg::in_t t;
    t.op         = aabb_pkg::OP_WRITE;
    t.box_index  = 4'(idx);
    t.new_x      = 16'(x);
    t.new_y      = 16'(y);
    t.box_width  = 16'(w);
    t.box_height = 16'(h);
    t.present    = p;
    t.vel_x      = 16'($urandom);
    t.vel_y      = 16'($urandom);
    t.step_time  = 16'($urandom);
    return t;
  endfunction

  // Move transaction; the write fields carry junk the block must ignore.
  function automatic aabb_pkg::in_t move_cmd(int idx, int vx, int vy, int st);
    aabb_pkg::in_t t;
    t.op         = aabb_pkg::OP_MOVE;
    t.box_index  = 4'(idx);
    t.new_x      = 16'($urandom);
    t.new_y      = 16'($urandom);
    t.box_width  = 16'($urandom);
    t.box_height = 16'($urandom);
    t.present    = 1'($urandom);
    t.vel_x      = 16'(vx);
    t.vel_y      = 16'(vy);
    t.step_time  = 16'(st);
    return t;
  endfunction

  // Mostly boxes packed into a small area so that moves collide often,
  // with some full-range noise and extreme velocities mixed in.
  function automatic aabb_pkg::in_t random_item();
    logic [159:0] raw;
    int           pick;
    int           vx;
    int           vy;
    int           st;
    pick = $urandom_range(99);
    if (pick < 8) begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return aabb_pkg::in_t'(raw[$bits(aabb_pkg::in_t)-1:0]);
    end
    if (pick < 35) begin
      if ($urandom_range(15) == 0)
        return write_cmd($urandom_range(15), $urandom, $urandom, $urandom, $urandom,
                         1'($urandom));
      return write_cmd($urandom_range(15), int'($urandom_range(3200)) - 1600,
                       int'($urandom_range(3200)) - 1600, $urandom_range(16, 640),
                       $urandom_range(16, 640), $urandom_range(9) != 0);
    end
    vx = int'($urandom_range(4000)) - 2000;
    vy = int'($urandom_range(4000)) - 2000;
    case ($urandom_range(9))
      0: begin
        vx = 0;
        vy = 0;
      end
      1: vx = 0;
      2: vy = 0;
      3: begin
        vx = $urandom;
        vy = $urandom;
      end
      default: ;
    endcase
    st = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(65535);
    return move_cmd($urandom_range(15), vx, vy, st);
  endfunction

  // Present one transaction, wait for acceptance, then keep the burst going
  // or idle for a random gap.
  task automatic send_item(input aabb_pkg::in_t t);
    @(negedge clk);
    item  <= t;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    table_sb.note_item(t);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      repeat ($urandom_range(1, 48)) begin
        @(negedge clk);
        start <= 1'b0;
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
    end
  endtask

  // Main sequence: reset, directed cases, random traffic, drain.
  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    burst_left = 0;
    table_sb   = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Moving an entry that was never written changes nothing.
    send_item(move_cmd(3, 16, 16, 65535));
    send_item(write_cmd(0, 0, 0, 160, 160, 1));
    send_item(write_cmd(1, 320, 0, 160, 160, 1));
    // Zero velocity, a displacement that rounds to zero, and a rounding tie.
    send_item(move_cmd(0, 0, 0, 65535));
    send_item(move_cmd(0, 1, 1, 1));
    send_item(move_cmd(0, 1, -1, 32768));
    // Push toward the neighbor: one blocked try, one that stops near its edge.
    send_item(move_cmd(0, 160, 0, 65535));
    send_item(move_cmd(0, 158, 0, 65535));
    // Saturation at both ends of the position range.
    send_item(move_cmd(0, 0, 32767, 65535));
    send_item(move_cmd(0, 0, 32767, 65535));
    send_item(move_cmd(0, -32768, -32768, 65535));
    send_item(move_cmd(0, -32768, -32768, 65535));
    // A box covering the whole plane blocks every move.
    send_item(write_cmd(15, -32768, -32768, 65535, 65535, 1));
    send_item(move_cmd(1, 16, 16, 65535));
    send_item(write_cmd(15, 32767, 32767, 0, 0, 1));
    send_item(move_cmd(15, 32767, 32767, 65535));
    // A cleared entry no longer moves; a zero step still counts as a move.
    send_item(write_cmd(1, 0, 0, 0, 0, 0));
    send_item(move_cmd(1, 100, 100, 65535));
    send_item(move_cmd(0, 100, 0, 0));
    send_item(write_cmd(2, 16, 16, 16, 16, 1));
    send_item(write_cmd(3, -32768, 32767, 65535, 0, 0));
    send_item(move_cmd(2, -16, -16, 65535));

    repeat (1950) send_item(random_item());
    @(negedge clk);
    start <= 1'b0;

    while (table_sb.positions_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (table_sb.errors == 0 && table_sb.positions_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
